// File: rtl/mpls_pkg.sv
`default_nettype none
package mpls_pkg;

  localparam int unsigned MaxMotorsDef = 8;
  localparam int unsigned CurW         = 16;
  localparam int unsigned LimW         = 10;
  localparam int unsigned AccW         = 64;

  localparam logic signed [AccW-1:0] K1Q48 = 64'sd34621422;
  localparam logic signed [AccW-1:0] K2Q48 = 64'sd40898314;
  localparam logic signed [AccW-1:0] KCQ48 = 64'sd562074564;
  localparam logic signed [AccW-1:0] K0Q32 = 64'sd17527761535;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_RUN
  } mul_state_t;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EST_A,
    ST_EST_B,
    ST_EST_C,
    ST_EST_SUM,
    ST_OUT_LOAD,
    ST_SOL_TGT,
    ST_SOL_DIV1,
    ST_SOL_C,
    ST_SOL_DIV2,
    ST_SOL_DIV3,
    ST_SOL_PP,
    ST_SOL_SQRT,
    ST_OUT_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_DONE
  } sq_state_t;

  function automatic logic signed [AccW-1:0] rshift_round(
    input logic signed [AccW-1:0] v, input int unsigned sh);
    logic signed [AccW-1:0] t;
    t = v + (64'sd1 <<< (sh - 1));
    return t >>> sh;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mpls_mul.sv
`default_nettype none
// bit-serial signed multiply, one multiplier bit per cycle
module mpls_mul (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [mpls_pkg::AccW-1:0] a,
  input  wire logic signed [mpls_pkg::AccW-1:0] b,
  output logic                                  done,
  output logic signed [mpls_pkg::AccW-1:0]      prod
);
  import mpls_pkg::*;

  mul_state_t             state_r, state_nxt;
  logic [AccW-1:0]        mcand_r, mcand_nxt;
  logic [AccW-1:0]        mplier_r, mplier_nxt;
  logic [AccW-1:0]        acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic [6:0]             cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MUL_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    neg_r    <= neg_nxt;
    cnt_r    <= cnt_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    unique case (state_r)
      MUL_IDLE: begin
        if (start) begin
          mcand_nxt  = a[AccW-1] ? 64'(-a) : a;
          mplier_nxt = b[AccW-1] ? 64'(-b) : b;
          neg_nxt    = a[AccW-1] ^ b[AccW-1];
          acc_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = MUL_RUN;
        end
      end
      MUL_RUN: begin
        if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          state_nxt = MUL_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = MUL_IDLE;
    endcase
  end

  assign done = done_r;
  assign prod = neg_r ? $signed(64'(-acc_r)) : $signed(acc_r);

endmodule
`default_nettype wire

// File: rtl/mpls_div.sv
`default_nettype none
// restoring divide: floor(n * 2^sh / d), one quotient bit per cycle
module mpls_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [mpls_pkg::AccW-1:0]  n,
  input  wire logic [6:0]                 sh,
  input  wire logic [mpls_pkg::AccW-1:0]  d,
  output logic                            done,
  output logic [mpls_pkg::AccW-1:0]       q
);
  import mpls_pkg::*;

  div_state_t         state_r, state_nxt;
  logic [AccW-1:0]    num_r, num_nxt;
  logic [AccW-1:0]    den_r, den_nxt;
  logic [AccW:0]      rem_r, rem_nxt;
  logic [AccW-1:0]    quo_r, quo_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [AccW:0]      sh_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= DIV_IDLE;
    else        state_r <= state_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    len_r <= len_nxt;
  end

  assign sh_rem = {rem_r[AccW-1:0], num_r[AccW-1]};

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    unique case (state_r)
      DIV_IDLE, DIV_DONE: begin
        state_nxt = DIV_IDLE;
        if (start) begin
          num_nxt   = n;
          den_nxt   = d;
          rem_nxt   = '0;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          len_nxt   = 8'(AccW) + {1'b0, sh};
          state_nxt = DIV_RUN;
        end
      end
      DIV_RUN: begin
        num_nxt = num_r << 1;
        quo_nxt = quo_r << 1;
        if (sh_rem >= {1'b0, den_r}) begin
          rem_nxt    = sh_rem - {1'b0, den_r};
          quo_nxt[0] = 1'b1;
        end else begin
          rem_nxt = sh_rem;
        end
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == len_r - 8'd1) state_nxt = DIV_DONE;
      end
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  assign done = (state_r == DIV_DONE);
  assign q    = quo_r;

endmodule
`default_nettype wire

// File: rtl/mpls_sqrt.sv
`default_nettype none
// bitwise integer square root, one result bit per cycle
module mpls_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [mpls_pkg::AccW-1:0]  v,
  output logic                            done,
  output logic [mpls_pkg::AccW-1:0]       root
);
  import mpls_pkg::*;

  sq_state_t        state_r, state_nxt;
  logic [AccW-1:0]  val_r, val_nxt;
  logic [AccW-1:0]  res_r, res_nxt;
  logic [AccW-1:0]  bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= SQ_IDLE;
    else        state_r <= state_nxt;
    val_r <= val_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (start) begin
          val_nxt   = v;
          res_nxt   = '0;
          bit_nxt   = 64'd1 << 62;
          state_nxt = SQ_RUN;
        end
      end
      SQ_RUN: begin
        if (val_r >= res_r + bit_r) begin
          val_nxt = val_r - (res_r + bit_r);
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) state_nxt = SQ_DONE;
      end
      SQ_DONE: state_nxt = SQ_IDLE;
      default: state_nxt = SQ_IDLE;
    endcase
  end

  assign done = (state_r == SQ_DONE);
  assign root = res_r;

endmodule
`default_nettype wire

// File: rtl/motor_power_limit_scaler.sv
`default_nettype none
// Motor power limit scaler.
// Input channel (in_valid/in_stall): one request per motor with current
// command, speed in rpm and a last-motor flag. Each request is stored and
// its power estimated by three serial multiplies; the next request is
// taken only once the block is back in idle.
// Requests beyond MAX_MOTORS are dropped; their last flag still counts.
// After the last request, one result per stored motor leaves on the output
// channel (out_valid/out_stall) in load order with index and last flag.
// Pass-through results use no serial unit; a limited motor runs three
// multiplies, two 64-step divides, one 96-step divide and a 32-step
// root on the serial units.
// cfg_valid/cfg_ready writes the watt limit; ready is high while idle.
// Synchronous active-low reset clears the run and the limit to zero.
// While out_stall is high the result holds and the next motor waits.
// in_stall is high whenever the block is busy.
module motor_power_limit_scaler #(
  parameter int unsigned MAX_MOTORS = mpls_pkg::MaxMotorsDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [15:0]  in_current_cmd,
  input  wire logic signed [15:0]  in_speed_rpm,
  input  wire logic                in_last_motor,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [15:0]       out_limited_current,
  output logic [2:0]               out_motor_index,
  output logic                     out_last_result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [9:0]          cfg_watt_limit
);
  import mpls_pkg::*;

  localparam int unsigned IdxW = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
  localparam int unsigned CntW = $clog2(MAX_MOTORS + 1);

  logic signed [15:0]      cur_mem [MAX_MOTORS];
  logic signed [15:0]      spd_mem [MAX_MOTORS];
  logic signed [AccW-1:0]  pw_mem  [MAX_MOTORS];

  ctl_state_t              state_r, state_nxt;
  logic [CntW-1:0]         cnt_r, cnt_nxt;
  logic [CntW-1:0]         k_r, k_nxt;
  logic signed [AccW-1:0]  total_r, total_nxt;
  logic [LimW-1:0]         lim_r;
  logic                    limiting_r, limiting_nxt;
  logic                    last_r, last_nxt;
  logic signed [15:0]      cur_r, cur_nxt;
  logic signed [15:0]      spd_r, spd_nxt;
  logic signed [AccW-1:0]  pw_r, pw_nxt;
  logic signed [AccW-1:0]  acc_r, acc_nxt;
  logic signed [AccW-1:0]  t1_r, t1_nxt;
  logic signed [AccW-1:0]  p_r, p_nxt;
  logic signed [AccW-1:0]  c_r, c_nxt;
  logic signed [AccW-1:0]  d_r, d_nxt;
  logic                    wr_en;
  logic [IdxW-1:0]         wr_idx;
  logic signed [15:0]      res_r, res_nxt;
  logic [2:0]              oidx_r, oidx_nxt;
  logic                    olast_r, olast_nxt;
  logic                    ovalid_r, ovalid_nxt;

  logic                    mul_start;
  logic signed [AccW-1:0]  mul_a, mul_b, mul_p;
  logic                    mul_done;
  logic                    div_start;
  logic [AccW-1:0]         div_n, div_d, div_q;
  logic [6:0]              div_sh;
  logic                    div_done;
  logic                    sq_start, sq_done;
  logic [AccW-1:0]         sq_v, sq_root;

  logic [IdxW-1:0]         rd_idx;
  logic signed [AccW-1:0]  root_q8, root_int;
  logic [AccW-1:0]         cm;
  logic signed [AccW-1:0]  qv;

  mpls_mul u_mul (.clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
                  .done(mul_done), .prod(mul_p));
  mpls_div u_div (.clk, .rst_n, .start(div_start), .n(div_n), .sh(div_sh),
                  .d(div_d), .done(div_done), .q(div_q));
  mpls_sqrt u_sqrt (.clk, .rst_n, .start(sq_start), .v(sq_v),
                    .done(sq_done), .root(sq_root));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      total_r  <= '0;
      lim_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      total_r  <= total_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_valid && cfg_ready) lim_r <= cfg_watt_limit;
    end
    k_r        <= k_nxt;
    limiting_r <= limiting_nxt;
    last_r     <= last_nxt;
    cur_r      <= cur_nxt;
    spd_r      <= spd_nxt;
    pw_r       <= pw_nxt;
    acc_r      <= acc_nxt;
    t1_r       <= t1_nxt;
    p_r        <= p_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    res_r      <= res_nxt;
    oidx_r     <= oidx_nxt;
    olast_r    <= olast_nxt;
    if (wr_en) begin
      cur_mem[wr_idx] <= cur_r;
      spd_mem[wr_idx] <= spd_r;
      pw_mem[wr_idx]  <= pw_nxt;
    end
  end

  assign rd_idx   = k_r[IdxW-1:0];
  assign wr_idx   = cnt_r[IdxW-1:0];
  assign root_q8  = (cur_r >= 0) ? (d_r - p_r) : (-p_r - d_r);
  assign root_int = rshift_round(root_q8, 8);
  assign cm       = c_r[AccW-1] ? 64'(-c_r) : c_r;
  assign qv       = c_r[AccW-1] ? $signed(64'(-div_q)) : $signed(div_q);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    total_nxt    = total_r;
    limiting_nxt = limiting_r;
    last_nxt     = last_r;
    cur_nxt      = cur_r;
    spd_nxt      = spd_r;
    pw_nxt       = pw_r;
    acc_nxt      = acc_r;
    t1_nxt       = t1_r;
    p_nxt        = p_r;
    c_nxt        = c_r;
    d_nxt        = d_r;
    res_nxt      = res_r;
    oidx_nxt     = oidx_r;
    olast_nxt    = olast_r;
    ovalid_nxt   = ovalid_r;
    wr_en        = 1'b0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_n        = '0;
    div_d        = 64'(K1Q48);
    div_sh       = '0;
    sq_start     = 1'b0;
    sq_v         = d_r;
    in_stall     = 1'b1;
    cfg_ready    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        if (in_valid) begin
          cur_nxt  = in_current_cmd;
          spd_nxt  = in_speed_rpm;
          last_nxt = in_last_motor;
          if (cnt_r < CntW'(MAX_MOTORS)) begin
            mul_start = 1'b1;
            mul_a     = K1Q48 * 64'(in_current_cmd);
            mul_b     = 64'(in_current_cmd);
            state_nxt = ST_EST_A;
          end else begin
            state_nxt = ST_OUT_LOAD;
            k_nxt     = '0;
            limiting_nxt = (lim_r != '0) && (total_r > $signed({22'd0, lim_r, 32'd0}));
            if (!in_last_motor) state_nxt = ST_IDLE;
          end
        end
      end
      ST_EST_A: begin
        if (mul_done) begin
          acc_nxt   = mul_p;
          mul_start = 1'b1;
          mul_a     = K2Q48 * 64'(spd_r);
          mul_b     = 64'(spd_r);
          state_nxt = ST_EST_B;
        end
      end
      ST_EST_B: begin
        if (mul_done) begin
          acc_nxt   = acc_r + mul_p;
          mul_start = 1'b1;
          mul_a     = KCQ48 * 64'(spd_r);
          mul_b     = 64'(cur_r);
          state_nxt = ST_EST_C;
        end
      end
      ST_EST_C: begin
        if (mul_done) begin
          acc_nxt   = acc_r + mul_p;
          state_nxt = ST_EST_SUM;
        end
      end
      ST_EST_SUM: begin
        pw_nxt = rshift_round(acc_r, 16) + K0Q32;
        wr_en  = 1'b1;
        if (pw_nxt > 0) total_nxt = total_r + pw_nxt;
        cnt_nxt = cnt_r + 1'b1;
        if (last_r) begin
          k_nxt        = '0;
          limiting_nxt = (lim_r != '0) &&
                         (total_nxt > $signed({22'd0, lim_r, 32'd0}));
          state_nxt    = ST_OUT_LOAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT_LOAD: begin
        if (k_r == cnt_r) begin
          cnt_nxt   = '0;
          total_nxt = '0;
          state_nxt = ST_IDLE;
        end else if (!ovalid_r) begin
          cur_nxt = cur_mem[rd_idx];
          spd_nxt = spd_mem[rd_idx];
          pw_nxt  = pw_mem[rd_idx];
          if (limiting_r && !pw_mem[rd_idx][AccW-1]) begin
            state_nxt = ST_SOL_TGT;
          end else begin
            res_nxt   = cur_mem[rd_idx];
            state_nxt = ST_OUT_EMIT;
          end
        end
      end
      ST_SOL_TGT: begin
        mul_start = 1'b1;
        mul_a     = pw_r;
        mul_b     = 64'(lim_r);
        state_nxt = ST_SOL_DIV1;
      end
      ST_SOL_DIV1: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n     = mul_p;
          div_d     = total_r;
          div_sh    = 7'd0;
          // speed term of c runs on the multiplier beside the divide
          mul_start = 1'b1;
          mul_a     = K2Q48 * 64'(spd_r);
          mul_b     = 64'(spd_r);
          state_nxt = ST_SOL_C;
        end
      end
      ST_SOL_C: begin
        if (mul_done) t1_nxt = rshift_round(mul_p, 16) + K0Q32;
        if (div_done) begin
          c_nxt     = t1_nxt - $signed(div_q);
          acc_nxt   = KCQ48 * 64'(spd_r);
          div_start = 1'b1;
          div_n     = (acc_nxt[AccW-1] ? 64'(-acc_nxt) : acc_nxt) << 7;
          div_sh    = 7'd0;
          state_nxt = ST_SOL_DIV2;
        end
      end
      ST_SOL_DIV2: begin
        if (div_done) begin
          p_nxt     = acc_r[AccW-1] ? $signed(64'(-div_q)) : $signed(div_q);
          div_start = 1'b1;
          div_n     = cm;
          div_sh    = 7'd32;
          state_nxt = ST_SOL_DIV3;
        end
      end
      ST_SOL_DIV3: begin
        if (div_done) begin
          d_nxt     = qv;
          mul_start = 1'b1;
          mul_a     = p_r;
          mul_b     = p_r;
          state_nxt = ST_SOL_PP;
        end
      end
      ST_SOL_PP: begin
        if (mul_done) begin
          d_nxt     = mul_p - d_r;
          if (d_nxt[AccW-1]) d_nxt = '0;
          state_nxt = ST_SOL_SQRT;
        end
      end
      ST_SOL_SQRT: begin
        sq_start = 1'b1;
        if (sq_done) begin
          d_nxt     = $signed(sq_root);
          state_nxt = ST_OUT_EMIT;
          sq_start  = 1'b0;
        end
      end
      ST_OUT_EMIT: begin
        if (limiting_r && !pw_r[AccW-1] && d_r == $signed(sq_root)) begin
          if (root_int > 64'sd32767)       res_nxt = 16'sh7fff;
          else if (root_int < -64'sd32768) res_nxt = -16'sh8000;
          else                             res_nxt = root_int[15:0];
        end
        oidx_nxt   = 3'(k_r);
        olast_nxt  = (k_r + 1'b1 == cnt_r);
        ovalid_nxt = 1'b1;
        k_nxt      = k_r + 1'b1;
        state_nxt  = ST_OUT_LOAD;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (ovalid_r && !out_stall) ovalid_nxt = (state_r == ST_OUT_EMIT);
  end

  assign out_valid           = ovalid_r;
  assign out_limited_current = res_r;
  assign out_motor_index     = oidx_r;
  assign out_last_result     = olast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MAX_MOTORS)) else $error("motor count overflow");
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> (state_r == ST_IDLE)) else $error("config while busy");

endmodule
`default_nettype wire

// File: verif/tb_motor_power_limit_scaler.sv
module tb_motor_power_limit_scaler;
  import mpls_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 400;
  localparam int unsigned HoldCycles = 3000;

  typedef struct packed {
    logic signed [15:0] current;
    logic [2:0]         index;
    logic               last;
  } limited_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_current_cmd;
  logic signed [15:0] in_speed_rpm;
  logic in_last_motor;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_limited_current;
  logic [2:0] out_motor_index;
  logic out_last_result;
  logic cfg_valid;
  logic cfg_ready;
  logic [9:0] cfg_watt_limit;

  motor_power_limit_scaler dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_current_cmd(in_current_cmd),
    .in_speed_rpm(in_speed_rpm),
    .in_last_motor(in_last_motor),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_limited_current(out_limited_current),
    .out_motor_index(out_motor_index),
    .out_last_result(out_last_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_watt_limit(cfg_watt_limit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint cur_mem[8];
  longint spd_mem[8];
  longint pwr_mem[8];
  longint total_pwr;
  int unsigned n_loaded;
  longint limit_w;
  limited_result_t pending_q[$];

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  logic held;
  event hold_start;
  int unsigned mismatches;
  longint unsigned cycles;

  function automatic longint rnd_shift(longint v, int unsigned sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sqrt_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint motor_power(longint cur, longint spd);
    longint sum;
    sum = K1Q48 * cur * cur + K2Q48 * spd * spd + KCQ48 * spd * cur;
    return rnd_shift(sum, 16) + K0Q32;
  endfunction

  function automatic logic signed [15:0] scaled_current(longint cur, longint spd,
                                                        longint pw);
    longint target, c, b, p, q, d, r, root, res;
    logic [127:0] wide;
    target = (pw * limit_w) / total_pwr;
    c = rnd_shift(K2Q48 * spd * spd, 16) + K0Q32 - target;
    b = KCQ48 * spd;
    p = ((b < 0 ? -b : b) * 128) / K1Q48;
    if (b < 0) p = -p;
    wide = 128'(c < 0 ? -c : c) << 32;
    wide = wide / 128'(K1Q48);
    q = longint'(wide[63:0]);
    if (c < 0) q = -q;
    d = p * p - q;
    if (d < 0) d = 0;
    r = sqrt_floor(longint'(d));
    root = (cur >= 0) ? (-p + r) : (-p - r);
    res = rnd_shift(root, 8);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  task automatic model_request(logic signed [15:0] cur, logic signed [15:0] spd,
                               logic last);
    longint pw;
    logic limiting;
    limited_result_t r;
    if (n_loaded < 8) begin
      pw = motor_power(longint'(cur), longint'(spd));
      cur_mem[n_loaded] = cur;
      spd_mem[n_loaded] = spd;
      pwr_mem[n_loaded] = pw;
      if (pw > 0) total_pwr += pw;
      n_loaded++;
    end
    if (last) begin
      limiting = limit_w != 0 && total_pwr > (limit_w <<< 32);
      for (int k = 0; k < n_loaded; k++) begin
        r.current = cur_mem[k][15:0];
        if (limiting && pwr_mem[k] >= 0)
          r.current = scaled_current(cur_mem[k], spd_mem[k], pwr_mem[k]);
        r.index = k[2:0];
        r.last = (k + 1 == n_loaded);
        pending_q.push_back(r);
      end
      n_loaded = 0;
      total_pwr = 0;
    end
  endtask

  task automatic send_request(logic signed [15:0] cur, logic signed [15:0] spd,
                              logic last);
    in_valid <= 1'b1;
    in_current_cmd <= cur;
    in_speed_rpm <= spd;
    in_last_motor <= last;
    do @(posedge clk); while (in_stall);
    model_request(cur, spd, last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_limit(logic [9:0] v);
    cfg_valid <= 1'b1;
    cfg_watt_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    limit_w = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(int unsigned snd, int unsigned rcv);
    send_idle_pct = snd;
    stall_pct = rcv;
  endtask

  function automatic logic signed [15:0] rnd_field(int unsigned span);
    if ($urandom_range(1) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(2 * span)) - $signed(span));
  endfunction

  task automatic send_run(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_request(rnd_field(20000), rnd_field(9000), i + 1 == n);
  endtask

  task automatic test_directed;
    set_limit(10'd100);
    send_request(16'sh7fff, 16'sh7fff, 1'b0);
    send_request(-16'sh8000, -16'sh8000, 1'b0);
    send_request(16'sd0, 16'sd0, 1'b0);
    send_request(16'sd16384, -16'sd8000, 1'b0);
    send_request(-16'sd16384, 16'sd8000, 1'b0);
    send_request(-16'sd1, 16'sd1, 1'b0);
    send_request(16'sh7fff, -16'sh8000, 1'b1);
    send_request(16'sd12000, 16'sd3000, 1'b1);
    drain();
    set_limit(10'd0);
    send_request(16'sh7fff, 16'sh7fff, 1'b0);
    send_request(-16'sh8000, 16'sd5000, 1'b1);
    drain();
    set_limit(10'd1023);
    send_request(16'sh7fff, 16'sh7fff, 1'b0);
    send_request(-16'sh8000, -16'sh8000, 1'b1);
    send_request(16'sd20, 16'sd100, 1'b1);
    drain();
    set_limit(10'd1);
    send_request(16'sd1, 16'sd0, 1'b0);
    send_request(-16'sd30000, 16'sd30000, 1'b1);
    drain();
  endtask

  task automatic test_store_full;
    set_limit(10'd150);
    for (int i = 0; i < 11; i++)
      send_request(rnd_field(20000), rnd_field(9000), i == 10);
    drain();
  endtask

  task automatic test_output_hold;
    set_idling(0, 0);
    set_limit(10'd200);
    -> hold_start;
    for (int r = 0; r < 3; r++) send_run(8);
    drain();
  endtask

  task automatic test_random(int unsigned n_req, int unsigned snd, int unsigned rcv);
    int unsigned sent, n;
    set_idling(snd, rcv);
    case ($urandom_range(3))
      0: set_limit(10'($urandom_range(1023)));
      1: set_limit(10'($urandom_range(40, 300)));
      default: set_limit(10'($urandom_range(1, 120)));
    endcase
    sent = 0;
    while (sent < n_req) begin
      n = $urandom_range(1, 10);
      send_run(n);
      sent += n;
    end
    drain();
  endtask

  initial begin
    held = 1'b0;
    forever begin
      @(hold_start);
      held = 1'b1;
      repeat (HoldCycles) @(posedge clk);
      held = 1'b0;
    end
  end

  always @(posedge clk) out_stall <= held || ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[motor_power_limit_scaler] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    limited_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: cur %0d idx %0d last %0d",
                   out_limited_current, out_motor_index, out_last_result);
      end else begin
        want = pending_q.pop_front();
        if (out_limited_current !== want.current || out_motor_index !== want.index ||
            out_last_result !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cur %0d idx %0d last %0d, got %0d %0d %0d",
                     want.current, want.index, want.last, out_limited_current,
                     out_motor_index, out_last_result);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    n_loaded = 0;
    total_pwr = 0;
    limit_w = 0;
    set_idling(0, 0);
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_current_cmd <= '0;
    in_speed_rpm <= '0;
    in_last_motor <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_watt_limit <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_output_hold();
    test_random(80, 0, 0);
    test_random(80, 86, 0);
    test_random(80, 0, 86);
    test_random(80, 33, 33);
    test_random(20, 0, 0);
    if (mismatches == 0) begin
      $display("[motor_power_limit_scaler] OK");
    end else begin
      $display("[motor_power_limit_scaler] ERROR");
    end
    $finish;
  end

endmodule
